@@ hdl/lru_key_table_macros.svh @@
// Assertion macros shared by the LRU key table modules.
`ifndef LRU_KEY_TABLE_MACROS_SVH
`define LRU_KEY_TABLE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LKT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define LKT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define LKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lkt_pkg.sv @@
// Package with the constants, types and helper functions of the LRU key table.
package lkt_pkg;

    localparam int SLOTS     = 16;
    localparam int KEY_BYTES = 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int SCAN_W    = SLOT_W + 1;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 4;
    localparam int OSLOT_W   = 4;
    localparam int OCNT_W    = 5;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EVICT
    } t_state;

    typedef struct packed {
        logic  en;
        logic  to_mru;
        t_slot slot;
    } t_rec_cmd;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = (len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len;
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            m[8*b +: 8] = {8{(LEN_W'(b) < len)}};
        end
        return m;
    endfunction

endpackage

@@ hdl/lkt_key_ram.sv @@
// Single-port-write, registered-read RAM holding the stored keys.
module lkt_key_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/lkt_recency.sv @@
// Recency list of slot numbers, least recent at position zero.
`include "lru_key_table_macros.svh"

module lkt_recency (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lkt_pkg::t_rec_cmd i_cmd,
    output lkt_pkg::t_slot    o_lru_slot
);
    import lkt_pkg::*;

    t_slot             r_order [SLOTS];
    t_slot             n_order [SLOTS];
    logic [SLOTS-1:0]  m;
    logic [SLOTS-1:0]  ge;
    logic [SLOTS-1:0]  le;

    always_comb begin
        for (int p = 0; p < SLOTS; p++) begin
            m[p] = (r_order[p] == i_cmd.slot);
        end
        for (int p = 0; p < SLOTS; p++) begin
            ge[p] = |(m & ({SLOTS{1'b1}} >> (SLOTS - 1 - p)));
            le[p] = |(m & ({SLOTS{1'b1}} << p));
        end
    end

    always_comb begin
        for (int p = 0; p < SLOTS; p++) begin
            n_order[p] = r_order[p];
        end
        if (i_cmd.to_mru) begin
            for (int p = 0; p < SLOTS - 1; p++) begin
                n_order[p] = ge[p] ? r_order[p+1] : r_order[p];
            end
            n_order[SLOTS-1] = i_cmd.slot;
        end else begin
            for (int p = 1; p < SLOTS; p++) begin
                n_order[p] = le[p] ? r_order[p-1] : r_order[p];
            end
            n_order[0] = i_cmd.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < SLOTS; p++) begin
                r_order[p] <= SLOT_W'(p);
            end
        end else if (i_cmd.en) begin
            for (int p = 0; p < SLOTS; p++) begin
                r_order[p] <= n_order[p];
            end
        end
    end

    assign o_lru_slot = r_order[0];

    // The list must stay a permutation, so a moved slot sits at exactly one position.
    `LKT_ASSERT_IMP(a_rec_perm, i_cmd.en, $onehot(m), "recency list lost its permutation")

endmodule

@@ hdl/lru_key_table.sv @@
// Top level of the LRU key table: sequencer, shared key comparator and slot state.
//
// Input channel: i_in_valid / o_in_ready carry one word of i_action, i_key and
// i_key_len. A word with length zero is taken and dropped without a result.
// Output channel: o_out_valid / i_out_ready carry one result word per kept
// input word, with found, slot, eviction details and the entry count.
// One comparator visits the stored slots one per cycle through the key RAM's
// registered read port, and a search stops early at the first match. The
// update state follows, and a lookup miss adds an eviction state to read the
// victim's key and write the new one. The next word is taken in the cycle
// after the result is registered.
// o_in_ready is high only while the sequencer is idle.
// If the receiver stalls, the result waits in the output register; a second
// result stays in the update or eviction stage until the first one has been taken.
// Reset is synchronous: all slots become empty, the count returns to zero and
// the recency order becomes ascending, so slot 0 is replaced first.
`include "lru_key_table_macros.svh"

module lru_key_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_action,
    input  logic [lkt_pkg::KEY_W-1:0]   i_key,
    input  logic [lkt_pkg::LEN_W-1:0]   i_key_len,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [lkt_pkg::OSLOT_W-1:0] o_slot,
    output logic                        o_evicted,
    output logic [lkt_pkg::KEY_W-1:0]   o_evicted_key,
    output logic [lkt_pkg::LEN_W-1:0]   o_evicted_len,
    output logic [lkt_pkg::OCNT_W-1:0]  o_item_count
);
    import lkt_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [SCAN_W-1:0]   r_cnt;
    logic [SCAN_W-1:0]   cnt_m1;
    t_slot               cmp_idx;
    logic                r_hit;
    t_slot               r_hit_slot;
    logic                r_action;
    logic [KEY_W-1:0]    r_key;
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    r_len_store [SLOTS];
    logic [SLOTS-1:0]    occ;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    logic                in_acc;
    logic [LEN_W-1:0]    in_len;
    t_slot               victim;
    t_slot               len_idx;
    logic [LEN_W-1:0]    len_rd;
    t_slot               ram_raddr;
    logic [KEY_W-1:0]    ram_rdata;
    logic                scan_match;
    logic                scan_end;
    logic                out_free;

    logic                commit;
    t_rec_cmd            rec_cmd;
    logic                ram_we;
    logic                len_we;
    t_slot               len_wslot;
    logic [LEN_W-1:0]    len_wdata;
    logic                n_found;
    t_slot               n_slot;
    logic                n_evicted;
    logic [KEY_W-1:0]    n_ev_key;
    logic [LEN_W-1:0]    n_ev_len;

    logic                r_o_valid;
    logic                r_o_found;
    logic [OSLOT_W-1:0]  r_o_slot;
    logic                r_o_evicted;
    logic [KEY_W-1:0]    r_o_ev_key;
    logic [LEN_W-1:0]    r_o_ev_len;
    logic [OCNT_W-1:0]   r_o_count;

    lkt_key_ram #(
        .DEPTH (SLOTS),
        .WIDTH (KEY_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (victim),
        .i_wdata (r_key),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lkt_recency u_recency (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (rec_cmd),
        .o_lru_slot (victim)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_len     = sat_len(i_key_len);
    assign cnt_m1     = r_cnt - SCAN_W'(1);
    assign cmp_idx    = cnt_m1[SLOT_W-1:0];
    assign len_idx    = (r_state == ST_SCAN) ? cmp_idx : victim;
    assign len_rd     = r_len_store[len_idx];
    assign ram_raddr  = (r_state == ST_SCAN) ? r_cnt[SLOT_W-1:0] : victim;
    assign scan_match = (r_state == ST_SCAN) && (r_cnt != '0)
                        && (len_rd == r_len) && (ram_rdata == r_key);
    assign scan_end   = (r_state == ST_SCAN)
                        && (scan_match || (r_cnt == SCAN_W'(SLOTS)));
    assign out_free   = !r_o_valid || i_out_ready;

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            occ[s] = (r_len_store[s] != '0);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_key_len != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!r_action && !r_hit) begin
                    n_state = ST_EVICT;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        commit         = 1'b0;
        rec_cmd.en     = 1'b0;
        rec_cmd.to_mru = 1'b1;
        rec_cmd.slot   = r_hit_slot;
        ram_we         = 1'b0;
        len_we         = 1'b0;
        len_wslot      = r_hit_slot;
        len_wdata      = '0;
        n_count        = r_count;
        n_found        = 1'b0;
        n_slot         = '0;
        n_evicted      = 1'b0;
        n_ev_key       = '0;
        n_ev_len       = '0;
        case (r_state)
            ST_UPDATE: begin
                if (r_action || r_hit) begin
                    commit  = out_free;
                    n_found = r_hit;
                    n_slot  = r_hit ? r_hit_slot : '0;
                end
                if (r_action && r_hit) begin
                    rec_cmd.en     = commit;
                    rec_cmd.to_mru = 1'b0;
                    len_we         = commit;
                    if (r_count != '0) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end else if (!r_action && r_hit) begin
                    rec_cmd.en = commit;
                end
            end
            ST_EVICT: begin
                commit       = out_free;
                n_slot       = victim;
                rec_cmd.en   = commit;
                rec_cmd.slot = victim;
                ram_we       = commit;
                len_we       = commit;
                len_wslot    = victim;
                len_wdata    = r_len;
                if (len_rd != '0) begin
                    n_evicted = 1'b1;
                    n_ev_key  = ram_rdata;
                    n_ev_len  = len_rd;
                end else if (r_count < CNT_W'(SLOTS)) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
                commit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_hit     <= 1'b0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_len_store[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + SCAN_W'(1);
                if (scan_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (len_we) begin
                r_len_store[len_wslot] <= len_wdata;
            end
            if (commit) begin
                r_count   <= n_count;
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_len    <= in_len;
            r_key    <= i_key & key_mask(in_len);
        end
        if (scan_match) begin
            r_hit_slot <= cmp_idx;
        end
        if (commit) begin
            r_o_found   <= n_found;
            r_o_slot    <= OSLOT_W'(n_slot);
            r_o_evicted <= n_evicted;
            r_o_ev_key  <= n_ev_key;
            r_o_ev_len  <= n_ev_len;
            r_o_count   <= OCNT_W'(n_count);
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_found       = r_o_found;
    assign o_slot        = r_o_slot;
    assign o_evicted     = r_o_evicted;
    assign o_evicted_key = r_o_ev_key;
    assign o_evicted_len = r_o_ev_len;
    assign o_item_count  = r_o_count;

    `LKT_ASSERT_ALWAYS(a_count_occ, $countones(occ) == 32'(r_count), "count differs from occupied slots")
    `LKT_ASSERT_ALWAYS(a_count_max, r_count <= CNT_W'(SLOTS), "entry count beyond table size")
    `LKT_ASSERT_IMP(a_evict_miss, r_state == ST_EVICT, !r_action && !r_hit, "eviction without a lookup miss")
    `LKT_ASSERT_NEXT(a_scan_start, in_acc && (i_key_len != '0), (r_state == ST_SCAN) && (r_cnt == '0), "search did not start")

endmodule

@@ tb/sv/lru_key_table_tb.sv @@
// Self-checking testbench for the LRU key table with a built-in table predictor.
`timescale 1ns / 1ps

module lru_key_table_tb;

    import lkt_pkg::*;

    localparam bit ACT_LOOKUP   = 1'b0;
    localparam bit ACT_DELETE   = 1'b1;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_WORDS = 1070;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct {
        bit               action;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] key_len;
        bit               hold;
    } t_word;

    typedef struct {
        logic               found;
        logic [OSLOT_W-1:0] slot;
        logic               evicted;
        logic [KEY_W-1:0]   ev_key;
        logic [LEN_W-1:0]   ev_len;
        logic [OCNT_W-1:0]  count;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_action = 1'b0;
    logic [KEY_W-1:0]   i_key = '0;
    logic [LEN_W-1:0]   i_key_len = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_found;
    logic [OSLOT_W-1:0] o_slot;
    logic               o_evicted;
    logic [KEY_W-1:0]   o_evicted_key;
    logic [LEN_W-1:0]   o_evicted_len;
    logic [OCNT_W-1:0]  o_item_count;

    // Predicted contents of the table.
    logic [KEY_W-1:0] stored_key [SLOTS];
    int               stored_len [SLOTS];
    int               recency [SLOTS];
    int               entry_count;

    t_word   pending_words[$];
    t_result expected_results[$];
    t_word   driven_word;
    t_result checked_want;
    t_result predicted;
    int      accepted_words;
    int      total_words;
    int      mismatch_count;
    int      cycle_count;

    lru_key_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_key_len     (i_key_len),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_slot        (o_slot),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .o_evicted_len (o_evicted_len),
        .o_item_count  (o_item_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] bytes_mask(input int len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (b < len) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic void promote_to_newest(input int s);
        int p;
        p = 0;
        while (recency[p] != s) begin
            p++;
        end
        for (; p + 1 < SLOTS; p++) begin
            recency[p] = recency[p + 1];
        end
        recency[SLOTS - 1] = s;
    endfunction

    // Applies one word to the predicted table; returns 0 when no result follows.
    function automatic bit predict_table_result(input t_word w, output t_result r);
        int               len;
        int               hit;
        int               victim;
        int               p;
        logic [KEY_W-1:0] k;
        r = '{default: '0};
        len = int'(w.key_len);
        if (len == 0) begin
            return 1'b0;
        end
        if (len > KEY_BYTES) begin
            len = KEY_BYTES;
        end
        k = w.key & bytes_mask(len);
        hit = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && stored_len[i] == len && stored_key[i] == k) begin
                hit = i;
            end
        end
        if (w.action == ACT_DELETE) begin
            if (hit >= 0) begin
                r.found = 1'b1;
                r.slot = OSLOT_W'(hit);
                stored_len[hit] = 0;
                if (entry_count > 0) begin
                    entry_count--;
                end
                p = 0;
                while (recency[p] != hit) begin
                    p++;
                end
                for (; p > 0; p--) begin
                    recency[p] = recency[p - 1];
                end
                recency[0] = hit;
            end
        end else if (hit >= 0) begin
            r.found = 1'b1;
            r.slot = OSLOT_W'(hit);
            promote_to_newest(hit);
        end else begin
            victim = recency[0];
            if (stored_len[victim] > 0) begin
                r.evicted = 1'b1;
                r.ev_key = stored_key[victim];
                r.ev_len = LEN_W'(stored_len[victim]);
            end else if (entry_count < SLOTS) begin
                entry_count++;
            end
            stored_key[victim] = k;
            stored_len[victim] = len;
            promote_to_newest(victim);
            r.slot = OSLOT_W'(victim);
        end
        r.count = OCNT_W'(entry_count);
        return 1'b1;
    endfunction

    function automatic int idle_phase();
        if (total_words == 0) begin
            return 0;
        end
        return (accepted_words * 3) / total_words;
    endfunction

    function automatic void add_word(input bit action, input logic [KEY_W-1:0] key,
                                     input int len, input bit hold);
        t_word w;
        w.action = action;
        w.key = key;
        w.key_len = LEN_W'(len);
        w.hold = hold;
        pending_words.push_back(w);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                accepted_words++;
                if (predict_table_result(driven_word, predicted)) begin
                    expected_results.push_back(predicted);
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() != 0
                        && !(pending_words[0].hold && expected_results.size() != 0)
                        && $urandom_range(0, 99) >= (idle_phase() == 0 ? 25 :
                                                     idle_phase() == 1 ? 51 : 0)) begin
                    driven_word = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_action <= driven_word.action;
                    i_key <= driven_word.key;
                    i_key_len <= driven_word.key_len;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word arrived with no expectation waiting");
                    mismatch_count++;
                end else begin
                    checked_want = expected_results.pop_front();
                    if (o_found !== checked_want.found) begin
                        $error("found: expected %0d, got %0d", checked_want.found, o_found);
                        mismatch_count++;
                    end
                    if (o_slot !== checked_want.slot) begin
                        $error("slot: expected %0d, got %0d", checked_want.slot, o_slot);
                        mismatch_count++;
                    end
                    if (o_evicted !== checked_want.evicted) begin
                        $error("evicted: expected %0d, got %0d", checked_want.evicted,
                               o_evicted);
                        mismatch_count++;
                    end
                    if (o_evicted_key !== checked_want.ev_key) begin
                        $error("evicted_key: expected %h, got %h", checked_want.ev_key,
                               o_evicted_key);
                        mismatch_count++;
                    end
                    if (o_evicted_len !== checked_want.ev_len) begin
                        $error("evicted_len: expected %0d, got %0d", checked_want.ev_len,
                               o_evicted_len);
                        mismatch_count++;
                    end
                    if (o_item_count !== checked_want.count) begin
                        $error("item_count: expected %0d, got %0d", checked_want.count,
                               o_item_count);
                        mismatch_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= (idle_phase() == 0 ? 51 :
                                                      idle_phase() == 1 ? 25 : 0));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lru_key_table_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] pool_key [POOL_SIZE];
        int               pool_len [POOL_SIZE];
        int               kept;
        int               pick;
        int               len;
        int               dice;
        logic [KEY_W-1:0] key;

        for (int i = 0; i < SLOTS; i++) begin
            stored_key[i] = '0;
            stored_len[i] = 0;
            recency[i] = i;
        end
        entry_count = 0;

        // Directed words: ignored lengths, saturation, stray bits, deletes and evictions.
        add_word(ACT_LOOKUP, 64'hDEAD_BEEF_0123_4567, 0, 1'b0);
        add_word(ACT_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
        add_word(ACT_DELETE, 64'h11, 1, 1'b0);
        add_word(ACT_LOOKUP, 64'h0, 1, 1'b0);
        add_word(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b0);
        add_word(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 15, 1'b0);
        add_word(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFAB, 1, 1'b0);
        add_word(ACT_LOOKUP, 64'h5A5A_0000_0000_12AB, 1, 1'b1);
        add_word(ACT_LOOKUP, 64'h0, 2, 1'b0);
        add_word(ACT_DELETE, 64'h8000_0000_0000_00AB, 1, 1'b0);
        add_word(ACT_LOOKUP, 64'h0123_4567, 4, 1'b0);
        add_word(ACT_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 9, 1'b0);
        for (int i = 0; i < 15; i++) begin
            add_word(ACT_LOOKUP, 64'h1000 + i, 2, 1'b0);
        end

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_len[i] = $urandom_range(1, KEY_BYTES);
            pool_key[i] = {$urandom, $urandom} & bytes_mask(pool_len[i]);
        end

        kept = 0;
        while (kept < RANDOM_WORDS) begin
            dice = $urandom_range(0, 99);
            if (dice < 5) begin
                add_word(1'($urandom_range(0, 1)), {$urandom, $urandom}, 0, 1'b0);
            end else begin
                if (dice < 13) begin
                    len = $urandom_range(1, 15);
                    key = {$urandom, $urandom};
                end else begin
                    if ($urandom_range(0, 49) == 0) begin
                        pick = $urandom_range(0, POOL_SIZE - 1);
                        pool_len[pick] = $urandom_range(1, KEY_BYTES);
                        pool_key[pick] = {$urandom, $urandom} & bytes_mask(pool_len[pick]);
                    end
                    pick = $urandom_range(0, POOL_SIZE - 1);
                    len = pool_len[pick];
                    if (len == KEY_BYTES && $urandom_range(0, 3) == 0) begin
                        len = $urandom_range(KEY_BYTES, 15);
                    end
                    key = pool_key[pick];
                    if ($urandom_range(0, 1) == 1) begin
                        key = key | ({$urandom, $urandom} & ~bytes_mask(len));
                    end
                end
                kept++;
                add_word($urandom_range(0, 3) == 0 ? ACT_DELETE : ACT_LOOKUP, key, len,
                         kept % 250 == 0);
            end
        end
        total_words = pending_words.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_words < total_words || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("lru_key_table_tb OK");
        end else begin
            $display("lru_key_table_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lkt_pkg.sv
hdl/lkt_key_ram.sv
hdl/lkt_recency.sv
hdl/lru_key_table.sv
tb/sv/lru_key_table_tb.sv
